/* design/multi_source_pose_averager_assert.svh */
// Assertion macros for the pose averager.
// Used by multi_source_pose_averager.sv; expects clk_i and rst_ni in scope.
`ifndef MULTI_SOURCE_POSE_AVERAGER_ASSERT_SVH
`define MULTI_SOURCE_POSE_AVERAGER_ASSERT_SVH

// Same-cycle implication
`define MPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/mpa_pkg.sv */
// Shared types, constants and sequencer states for the pose averager.
// No dependencies.
package mpa_pkg;

  localparam int Slots  = 16;
  localparam int SlotW  = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int CntW   = $clog2(Slots + 1);
  localparam int SumW   = 32 + CntW;
  localparam int DivW   = SumW + 1;
  localparam int DivCW  = $clog2(DivW + 1);

  localparam logic [14:0] OneQ14 = 15'd16384;

  localparam logic ModeUpdate = 1'b0;
  localparam logic ModeTick   = 1'b1;

  localparam logic [1:0] StatNew      = 2'd0;
  localparam logic [1:0] StatNoSlot   = 2'd1;
  localparam logic [1:0] StatZeroNorm = 2'd2;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } pose_t;

  typedef struct packed {
    logic             wr_en;
    logic [SlotW-1:0] wr_addr;
    logic [SlotW-1:0] rd_addr;
    logic             clr;
  } store_ctl_t;

  typedef enum logic [3:0] {
    SqIdle,
    SqRead,
    SqAdd,
    SqDivGo,
    SqDivWait,
    SqSqGo,
    SqSqAcc,
    SqNrmSq,
    SqNrmRhs,
    SqNrmChk,
    SqNrmT2,
    SqNrmCmp,
    SqFin
  } seq_state_e;

endpackage

/* design/mpa_store.sv */
// Slot pose memory with one valid flag per slot.
// Depends on mpa_pkg.
module mpa_store import mpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  store_ctl_t       ctl_i,
  input  pose_t            wr_data_i,
  output pose_t            rd_data_o,
  output logic [Slots-1:0] flags_o
);

  pose_t            mem_q [Slots];
  pose_t            rd_data_q;
  logic [Slots-1:0] flags_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[ctl_i.wr_addr] <= wr_data_i;
    end
    rd_data_q <= mem_q[ctl_i.rd_addr];
  end

  // Set a flag on write, drop all on clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (ctl_i.clr) begin
      flags_q <= '0;
    end else if (ctl_i.wr_en) begin
      flags_q[ctl_i.wr_addr] <= 1'b1;
    end
  end

  assign rd_data_o = rd_data_q;
  assign flags_o   = flags_q;

endmodule

/* design/mpa_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on mpa_pkg.
module mpa_div import mpa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [CntW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);

  logic             busy_q;
  logic             done_q;
  logic [DivCW-1:0] cnt_q;
  logic [DivW-1:0]  quo_q;
  logic [CntW-1:0]  rem_q;
  logic [CntW-1:0]  dvs_q;
  logic [CntW:0]    trial;
  logic             fits;

  assign trial = {rem_q, quo_q[DivW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift in one dividend bit, subtract where it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? CntW'(trial - {1'b0, dvs_q}) : CntW'(trial);
      quo_q <= {quo_q[DivW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* design/mpa_mul.sv */
// Shared 32 x 32 unsigned multiplier with a registered product.
// Depends on mpa_pkg.
module mpa_mul import mpa_pkg::*; (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  // Register the product
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i);
  end

  assign prod_o = prod_q;

endmodule

/* design/multi_source_pose_averager.sv */
// Pose averager top level: sequencer, slot store, serial divider, shared multiplier.
// Depends on mpa_pkg, mpa_store, mpa_div, mpa_mul and the assertion macro header.
// An update is taken and gives no result. A tick result is built by a walk of read and
// add states per slot, seven serial divisions and a square-root search on the shared
// multiplier. No new item is taken until the result is loaded into the output register;
// the sequencer stalls while a result waits. Reset clears all flags.
`include "multi_source_pose_averager_assert.svh"

module multi_source_pose_averager import mpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [3:0]         slot_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] avg_x_o,
  output logic signed [31:0] avg_y_o,
  output logic signed [31:0] avg_z_o,
  output logic signed [15:0] avg_qx_o,
  output logic signed [15:0] avg_qy_o,
  output logic signed [15:0] avg_qz_o,
  output logic signed [15:0] avg_qw_o,
  output logic [3:0]         source_slot_o,
  output logic [4:0]         used_count_o,
  output logic [1:0]         status_o
);

  seq_state_e state_q, state_d;

  logic [SlotW-1:0]       idx_q, idx_d;
  logic [2:0]             k_q, k_d;
  logic signed [SumW-1:0] sum_q [7];
  logic signed [SumW-1:0] sum_d [7];
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [SlotW-1:0]       first_q, first_d;
  logic                   found_q, found_d;
  logic signed [31:0]     avg_q [7];
  logic signed [31:0]     avg_d [7];
  logic signed [15:0]     nq_q [4];
  logic signed [15:0]     nq_d [4];
  logic [33:0]            s2_q, s2_d;
  logic [63:0]            rhs_q, rhs_d;
  logic [14:0]            lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [31:0]            t2_q, t2_d;
  logic [1:0]             status_q, status_d;

  pose_t                  held_q;
  logic [3:0]             held_src_q;
  pose_t                  out_q;
  logic [3:0]             out_src_q;
  logic [4:0]             out_cnt_q;
  logic [1:0]             out_stat_q;
  logic                   out_valid_q;
  logic                   out_load;

  store_ctl_t             st_ctl;
  pose_t                  wr_pose, rd_pose;
  logic [Slots-1:0]       flags;
  logic [6:0]             slot_ext;
  logic [SumW-1:0]        pose_ext [7];

  logic                   div_start, div_done;
  logic [DivW-1:0]        dividend, quot;
  logic [SumW-1:0]        sum_mag;
  logic                   sum_neg;

  logic [31:0]            mul_a, mul_b;
  logic [63:0]            prod;
  logic [2:0]             qidx;
  logic [31:0]            qmag;
  logic [15:0]            mid_sum, tval;
  logic [63:0]            pcmp;
  logic [31:0]            q32;

  logic                   cmp_pend_q;
  logic [14:0]            lo_cmp, hi_cmp;
  logic [14:0]            lo_fix, hi_fix;

  assign slot_ext = 7'(slot_i);
  assign wr_pose  = '{pos_x: pos_x_i, pos_y: pos_y_i, pos_z: pos_z_i, quat_x: quat_x_i,
                      quat_y: quat_y_i, quat_z: quat_z_i, quat_w: quat_w_i};

  mpa_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (st_ctl),
    .wr_data_i (wr_pose),
    .rd_data_o (rd_pose),
    .flags_o   (flags)
  );

  mpa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  mpa_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Sign-extend the stored pose fields to sum width
  assign pose_ext[0] = SumW'(rd_pose.pos_x);
  assign pose_ext[1] = SumW'(rd_pose.pos_y);
  assign pose_ext[2] = SumW'(rd_pose.pos_z);
  assign pose_ext[3] = SumW'(rd_pose.quat_x);
  assign pose_ext[4] = SumW'(rd_pose.quat_y);
  assign pose_ext[5] = SumW'(rd_pose.quat_z);
  assign pose_ext[6] = SumW'(rd_pose.quat_w);

  // Datapath helpers shared by the sequencer
  assign sum_neg  = sum_q[k_q][SumW-1];
  assign sum_mag  = sum_neg ? SumW'(-sum_q[k_q]) : SumW'(sum_q[k_q]);
  assign dividend = DivW'(sum_mag) + DivW'(cnt_q >> 1);
  assign q32      = quot[31:0];
  assign qidx     = 3'd3 + k_q;
  assign qmag     = avg_q[qidx][31] ? 32'(-avg_q[qidx]) : 32'(avg_q[qidx]);
  assign mid_sum  = (16'(lo_fix) + 16'(hi_fix) + 16'd1) >> 1;
  assign tval     = {mid_q, 1'b0} - 16'd1;
  assign pcmp     = prod + (s2_q[32] ? {t2_q, 32'd0} : 64'd0);
  assign out_load = (state_q == SqFin) && (!out_valid_q || out_ready_i);

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SqIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    k_q      <= k_d;
    sum_q    <= sum_d;
    cnt_q    <= cnt_d;
    first_q  <= first_d;
    found_q  <= found_d;
    avg_q    <= avg_d;
    nq_q     <= nq_d;
    s2_q     <= s2_d;
    rhs_q    <= rhs_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    t2_q     <= t2_d;
    status_q <= status_d;
  end

  // Next state and datapath control
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    k_d       = k_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    first_d   = first_q;
    found_d   = found_q;
    avg_d     = avg_q;
    nq_d      = nq_q;
    s2_d      = s2_q;
    rhs_d     = rhs_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    t2_d      = t2_q;
    status_d  = status_q;
    in_ready_o = 1'b0;
    st_ctl    = '{wr_en: 1'b0, wr_addr: slot_ext[SlotW-1:0],
                  rd_addr: idx_q, clr: 1'b0};
    div_start = 1'b0;
    mul_a     = qmag;
    mul_b     = qmag;
    case (state_q)
      SqIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (mode_i == ModeUpdate) begin
            st_ctl.wr_en = 32'(slot_i) < Slots;
          end else begin
            for (int j = 0; j < 7; j++) begin
              sum_d[j] = '0;
            end
            cnt_d   = '0;
            found_d = 1'b0;
            first_d = '0;
            idx_d   = '0;
            state_d = SqRead;
          end
        end
      end
      SqRead: begin
        state_d = SqAdd;
      end
      SqAdd: begin
        if (flags[idx_q]) begin
          for (int j = 0; j < 7; j++) begin
            sum_d[j] = sum_q[j] + pose_ext[j];
          end
          cnt_d = cnt_q + 1'b1;
          if (!found_q) begin
            found_d = 1'b1;
            first_d = idx_q;
          end
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == SlotW'(Slots - 1)) begin
          st_ctl.clr = 1'b1;
          k_d = '0;
          if (cnt_d == '0) begin
            status_d = StatNoSlot;
            state_d  = SqFin;
          end else begin
            state_d = SqDivGo;
          end
        end else begin
          state_d = SqRead;
        end
      end
      SqDivGo: begin
        div_start = 1'b1;
        state_d   = SqDivWait;
      end
      SqDivWait: begin
        if (div_done) begin
          avg_d[k_q] = sum_neg ? -q32 : q32;
          if (k_q == 3'd6) begin
            k_d   = '0;
            s2_d  = '0;
            state_d = SqSqGo;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = SqDivGo;
          end
        end
      end
      SqSqGo: begin
        state_d = SqSqAcc;
      end
      SqSqAcc: begin
        s2_d = s2_q + prod[33:0];
        if (k_q == 3'd3) begin
          k_d = '0;
          if (s2_d == '0) begin
            status_d = StatZeroNorm;
            state_d  = SqFin;
          end else begin
            state_d = SqNrmSq;
          end
        end else begin
          k_d     = k_q + 1'b1;
          state_d = SqSqGo;
        end
      end
      SqNrmSq: begin
        state_d = SqNrmRhs;
      end
      SqNrmRhs: begin
        rhs_d   = prod << 30;
        lo_d    = '0;
        hi_d    = OneQ14;
        state_d = SqNrmChk;
      end
      SqNrmChk: begin
        // Advance the bounds by the last compare, then split again or finish
        lo_d = lo_fix;
        hi_d = hi_fix;
        if (lo_fix < hi_fix) begin
          mid_d   = mid_sum[14:0];
          state_d = SqNrmT2;
        end else begin
          nq_d[k_q[1:0]] = avg_q[qidx][31] ? -16'(lo_fix) : 16'(lo_fix);
          if (k_q == 3'd3) begin
            status_d = StatNew;
            state_d  = SqFin;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = SqNrmSq;
          end
        end
      end
      SqNrmT2: begin
        // Square the trial boundary 2*mid-1
        mul_a   = 32'(tval);
        mul_b   = 32'(tval);
        state_d = SqNrmCmp;
      end
      SqNrmCmp: begin
        // Hold the square; scale it by the low word of the norm sum
        t2_d    = prod[31:0];
        mul_a   = prod[31:0];
        mul_b   = s2_q[31:0];
        state_d = SqNrmChk;
      end
      SqFin: begin
        if (out_load) begin
          state_d = SqIdle;
        end
      end
      default: begin
        state_d = SqIdle;
      end
    endcase
  end

  // Search step compare, in the cycle after the scaled square is issued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_pend_q <= 1'b0;
    end else begin
      cmp_pend_q <= (state_q == SqNrmCmp);
    end
  end

  // Apply the compare result to the search bounds
  always_comb begin
    lo_cmp = lo_q;
    hi_cmp = hi_q;
    if (pcmp <= rhs_q) begin
      lo_cmp = mid_q;
    end else begin
      hi_cmp = mid_q - 1'b1;
    end
  end

  // Bound registers see the compare in the cycle after the scaled square
  assign lo_fix = cmp_pend_q ? lo_cmp : lo_q;
  assign hi_fix = cmp_pend_q ? hi_cmp : hi_q;

  // Held pose and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '{pos_x: '0, pos_y: '0, pos_z: '0, quat_x: '0, quat_y: '0,
                       quat_z: '0, quat_w: 16'(OneQ14)};
      held_src_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      out_src_q   <= '0;
      out_cnt_q   <= '0;
      out_stat_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_cnt_q   <= 5'(cnt_q);
        out_stat_q  <= status_q;
        if (status_q == StatNew) begin
          held_q     <= '{pos_x: avg_q[0], pos_y: avg_q[1], pos_z: avg_q[2],
                          quat_x: nq_q[0], quat_y: nq_q[1], quat_z: nq_q[2],
                          quat_w: nq_q[3]};
          held_src_q <= 4'(first_q);
          out_q      <= '{pos_x: avg_q[0], pos_y: avg_q[1], pos_z: avg_q[2],
                          quat_x: nq_q[0], quat_y: nq_q[1], quat_z: nq_q[2],
                          quat_w: nq_q[3]};
          out_src_q  <= 4'(first_q);
        end else begin
          out_q     <= held_q;
          out_src_q <= held_src_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign avg_x_o       = out_q.pos_x;
  assign avg_y_o       = out_q.pos_y;
  assign avg_z_o       = out_q.pos_z;
  assign avg_qx_o      = out_q.quat_x;
  assign avg_qy_o      = out_q.quat_y;
  assign avg_qz_o      = out_q.quat_z;
  assign avg_qw_o      = out_q.quat_w;
  assign source_slot_o = out_src_q;
  assign used_count_o  = out_cnt_q;
  assign status_o      = out_stat_q;

  `MPA_ASSERT_NOW(a_load_free, out_load, !out_valid_q || out_ready_i, "result overwritten")
  `MPA_ASSERT_NOW(a_noslot_cnt, out_valid_o && status_o == StatNoSlot, used_count_o == 5'd0,
                  "held result with nonzero count")
  `MPA_ASSERT_NEXT(a_tick_walk, in_valid_i && in_ready_o && mode_i == ModeTick,
                   state_q == SqRead, "tick did not start the walk")

endmodule

/* verif/tb_multi_source_pose_averager.sv */
// Self-checking testbench for the multi-source pose averager.
// Depends on mpa_pkg and the multi_source_pose_averager RTL; predicts ticks and scores results.
`timescale 1ns / 100ps

module tb_multi_source_pose_averager import mpa_pkg::*;;

  typedef struct {
    logic signed [31:0] ax, ay, az;
    logic signed [15:0] qx, qy, qz, qw;
    logic [3:0] src;
    logic [4:0] cnt;
    logic [1:0] st;
  } avg_res_t;

  // Predicts tick results from noted updates and checks them in order.
  class pose_scoreboard;
    longint pos_st[16][3];
    longint q_st[16][4];
    bit vld[16];
    longint held_p[3];
    longint held_q[4];
    logic [3:0] held_src;
    avg_res_t pending[$];
    int errors;

    function void init();
      foreach (vld[i]) vld[i] = 0;
      foreach (held_p[i]) held_p[i] = 0;
      foreach (held_q[i]) held_q[i] = 0;
      held_q[3] = 16384;
      held_src = 0;
      errors = 0;
    endfunction

    // Queue one expected result at the back
    function void add_expected(avg_res_t r);
      pending.insert(pending.size(), r);
    endfunction

    function longint round_div(longint s, longint n);
      longint m;
      m = (s < 0) ? -s : s;
      m = (m + n / 2) / n;
      return (s < 0) ? -m : m;
    endfunction

    // Binary search for round(|a| * 2^14 / sqrt(s)), halves up
    function longint unit_comp(longint a, longint s);
      longint m, rhs, lo, hi, mid, t;
      m = (a < 0) ? -a : a;
      rhs = (m * m) << 30;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        t = 2 * mid - 1;
        if (t * t * s <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return (a < 0) ? -lo : lo;
    endfunction

    function avg_res_t held_res(logic [4:0] cnt, logic [1:0] st);
      avg_res_t r;
      r.ax = 32'(held_p[0]); r.ay = 32'(held_p[1]); r.az = 32'(held_p[2]);
      r.qx = 16'(held_q[0]); r.qy = 16'(held_q[1]); r.qz = 16'(held_q[2]);
      r.qw = 16'(held_q[3]);
      r.src = held_src; r.cnt = cnt; r.st = st;
      return r;
    endfunction

    function void note_input(logic m, logic [3:0] sl, logic signed [31:0] px, py, pz,
                             logic signed [15:0] qx, qy, qz, qw);
      longint sum[7];
      longint qa[4];
      longint n, s2;
      logic [3:0] first;
      if (m == ModeUpdate) begin
        pos_st[sl][0] = px; pos_st[sl][1] = py; pos_st[sl][2] = pz;
        q_st[sl][0] = qx; q_st[sl][1] = qy; q_st[sl][2] = qz; q_st[sl][3] = qw;
        vld[sl] = 1;
        return;
      end
      foreach (sum[i]) sum[i] = 0;
      n = 0;
      first = 0;
      for (int i = 15; i >= 0; i--)
        if (vld[i]) begin
          first = 4'(i);
          n++;
          for (int k = 0; k < 3; k++) sum[k] += pos_st[i][k];
          for (int k = 0; k < 4; k++) sum[3+k] += q_st[i][k];
        end
      foreach (vld[i]) vld[i] = 0;
      if (n == 0) begin
        add_expected(held_res(5'd0, StatNoSlot));
        return;
      end
      s2 = 0;
      for (int k = 0; k < 4; k++) begin
        qa[k] = round_div(sum[3+k], n);
        s2 += qa[k] * qa[k];
      end
      if (s2 == 0) begin
        add_expected(held_res(5'(n), StatZeroNorm));
        return;
      end
      for (int k = 0; k < 3; k++) held_p[k] = round_div(sum[k], n);
      for (int k = 0; k < 4; k++) held_q[k] = unit_comp(qa[k], s2);
      held_src = first;
      add_expected(held_res(5'(n), StatNew));
    endfunction

    function void check_result(avg_res_t a);
      avg_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result avg_x=%0d status=%0d", $time, a.ax, a.st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.ax !== e.ax || a.ay !== e.ay || a.az !== e.az || a.qx !== e.qx ||
          a.qy !== e.qy || a.qz !== e.qz || a.qw !== e.qw || a.src !== e.src ||
          a.cnt !== e.cnt || a.st !== e.st) begin
        $display("%0t: mismatch expected p=(%0d,%0d,%0d) q=(%0d,%0d,%0d,%0d) src=%0d n=%0d st=%0d",
                 $time, e.ax, e.ay, e.az, e.qx, e.qy, e.qz, e.qw, e.src, e.cnt, e.st);
        $display("%0t:          actual   p=(%0d,%0d,%0d) q=(%0d,%0d,%0d,%0d) src=%0d n=%0d st=%0d",
                 $time, a.ax, a.ay, a.az, a.qx, a.qy, a.qz, a.qw, a.src, a.cnt, a.st);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, mode_i;
  logic [3:0] slot_i;
  logic signed [31:0] pos_x_i, pos_y_i, pos_z_i;
  logic signed [15:0] quat_x_i, quat_y_i, quat_z_i, quat_w_i;
  logic out_valid_o, out_ready_i;
  logic signed [31:0] avg_x_o, avg_y_o, avg_z_o;
  logic signed [15:0] avg_qx_o, avg_qy_o, avg_qz_o, avg_qw_o;
  logic [3:0] source_slot_o;
  logic [4:0] used_count_o;
  logic [1:0] status_o;

  pose_scoreboard pose_sb;
  bit idle_on;
  bit hold_off;
  longint cycles;

  multi_source_pose_averager uut (.*);

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort on a runaway simulation
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("[multi_source_pose_averager] ERROR");
      $finish;
    end
  end

  // Note accepted inputs and check accepted results
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      pose_sb.note_input(mode_i, slot_i, pos_x_i, pos_y_i, pos_z_i,
                         quat_x_i, quat_y_i, quat_z_i, quat_w_i);
    if (rst_ni && out_valid_o && out_ready_i)
      pose_sb.check_result('{avg_x_o, avg_y_o, avg_z_o, avg_qx_o, avg_qy_o, avg_qz_o,
                             avg_qw_o, source_slot_o, used_count_o, status_o});
  end

  // Receiver: random stall bursts, or a long hold-off on request
  initial begin
    int gap;
    out_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 0;
        repeat (3000) @(posedge clk_i);
        hold_off = 0;
      end
      if (idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 9);
        out_ready_i <= 0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1;
    end
  end

  // Offer one item and hold it until the transfer
  task automatic send_item(logic m, logic [3:0] sl, logic signed [31:0] px, py, pz,
                           logic signed [15:0] qx, qy, qz, qw);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    mode_i <= m; slot_i <= sl;
    pos_x_i <= px; pos_y_i <= py; pos_z_i <= pz;
    quat_x_i <= qx; quat_y_i <= qy; quat_z_i <= qz; quat_w_i <= qw;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic signed [15:0] rand_quat();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'($urandom);
    if (r == 1) return (($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384);
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  task automatic send_update(logic [3:0] sl);
    send_item(ModeUpdate, sl, $urandom, $urandom, $urandom,
              rand_quat(), rand_quat(), rand_quat(), rand_quat());
  endtask

  task automatic send_tick();
    send_item(ModeTick, 4'($urandom), $urandom, $urandom, $urandom,
              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Drop valid and wait until every expected result has come
  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pose_sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int nupd;
    pose_sb = new();
    pose_sb.init();
    cycles = 0;
    idle_on = 0;
    hold_off = 0;
    in_valid_i = 0; mode_i = 0; slot_i = 0;
    pos_x_i = 0; pos_y_i = 0; pos_z_i = 0;
    quat_x_i = 0; quat_y_i = 0; quat_z_i = 0; quat_w_i = 0;
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty tick, extremes, zero norm, overwrite, all slots
    send_tick();
    send_item(ModeUpdate, 4'd15, 32'sh7fffffff, 32'sh80000000, 32'sd0,
              16'sd16384, -16'sd16384, 16'sd0, 16'sd0);
    send_item(ModeUpdate, 4'd0, 32'sh7fffffff, 32'sh80000000, -32'sd1,
              -16'sd16384, 16'sd16384, 16'sh7fff, 16'sh8000);
    send_tick();
    send_item(ModeUpdate, 4'd3, 32'sd5, -32'sd5, 32'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_item(ModeUpdate, 4'd4, 32'sd6, -32'sd6, 32'sd2, -16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_tick();
    send_item(ModeUpdate, 4'd7, 32'sd1, 32'sd2, 32'sd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_tick();
    send_item(ModeUpdate, 4'd9, 32'sd1, 32'sd2, 32'sd3, 16'sd1, 16'sd1, 16'sd1, 16'sd1);
    send_item(ModeUpdate, 4'd9, -32'sd7, 32'sd8, 32'sd9, 16'sd0, -16'sd3, 16'sd4, 16'sd0);
    send_tick();
    send_item(ModeUpdate, 4'd1, 32'sd1, 32'sd1, 32'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_item(ModeUpdate, 4'd2, 32'sd2, 32'sd2, 32'sd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_tick();
    for (int i = 0; i < 16; i++) send_update(4'(i));
    send_tick();
    drain();

    // Random: bursts of updates then a tick, with idling on both sides
    idle_on = 1;
    for (int b = 0; b < 160; b++) begin
      if (b == 40) hold_off = 1;
      if (b == 80) drain();
      nupd = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 6);
      for (int u = 0; u < nupd; u++) send_update(4'($urandom));
      send_tick();
    end
    // Final stretch with no idling
    idle_on = 0;
    for (int b = 0; b < 40; b++) begin
      nupd = $urandom_range(0, 5);
      for (int u = 0; u < nupd; u++) send_update(4'($urandom));
      send_tick();
    end
    drain();
    repeat (600) @(posedge clk_i);
    if (pose_sb.errors == 0 && pose_sb.pending.size() == 0)
      $display("[multi_source_pose_averager] OK");
    else
      $display("[multi_source_pose_averager] ERROR");
    $finish;
  end

endmodule
